// ===== rtl/fhps_pkg.sv =====
// ----------------------------------------------------------------------------
// fhps_pkg
// Types and constants shared by the frame header parser with sum check.
// ----------------------------------------------------------------------------
package fhps_pkg;

    localparam int ByteW  = 8;
    localparam int AddrW  = 24;
    localparam int CodeW  = 16;
    localparam int ClassW = 2;
    localparam int IdxW   = 2;

    // messages shorter than this are flagged too short
    localparam logic [ByteW-1:0] MinLength = 8'd9;
    localparam logic [ByteW-1:0] MaxLength = 8'd255;

    // configuration register indexes
    localparam logic [IdxW-1:0] CfgLevel  = 2'd0;
    localparam logic [IdxW-1:0] CfgTimer  = 2'd1;
    localparam logic [IdxW-1:0] CfgStatus = 2'd2;

    // reset values of the type code registers
    localparam logic [CodeW-1:0] LevelReset  = 16'h22F1;
    localparam logic [CodeW-1:0] TimerReset  = 16'h22F3;
    localparam logic [CodeW-1:0] StatusReset = 16'h31DA;

    // type class codes
    localparam logic [ClassW-1:0] ClassUnknown = 2'd0;
    localparam logic [ClassW-1:0] ClassLevel   = 2'd1;
    localparam logic [ClassW-1:0] ClassTimer   = 2'd2;
    localparam logic [ClassW-1:0] ClassStatus  = 2'd3;

    typedef struct packed {
        logic [CodeW-1:0] level;
        logic [CodeW-1:0] timer;
        logic [CodeW-1:0] status;
    } t_type_codes;

    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] byte_value;
        logic             is_last;
    } t_in_item;

    typedef struct packed {
        logic [AddrW-1:0]  src_addr;
        logic [AddrW-1:0]  dst_addr;
        logic [CodeW-1:0]  type_code;
        logic [ClassW-1:0] type_class;
        logic              checksum_ok;
        logic              too_short;
        logic [ByteW-1:0]  message_length;
    } t_result;

endpackage

// ===== rtl/fhps_cfg.sv =====
// ----------------------------------------------------------------------------
// fhps_cfg
// Type code registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module fhps_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [fhps_pkg::IdxW-1:0]   i_cfg_index,
    input  logic [fhps_pkg::CodeW-1:0]  i_cfg_data,
    output logic                        o_cfg_ready,
    output fhps_pkg::t_type_codes       o_codes
);

    fhps_pkg::t_type_codes r_codes;
    fhps_pkg::t_type_codes n_codes;

    assign o_cfg_ready = 1'b1;
    assign o_codes     = r_codes;

    always_comb begin
        n_codes = r_codes;
        if (i_cfg_valid) begin
            // index beyond the list is dropped
            unique case (i_cfg_index)
                fhps_pkg::CfgLevel:  n_codes.level  = i_cfg_data;
                fhps_pkg::CfgTimer:  n_codes.timer  = i_cfg_data;
                fhps_pkg::CfgStatus: n_codes.status = i_cfg_data;
                default:             n_codes        = r_codes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.level  <= fhps_pkg::LevelReset;
            r_codes.timer  <= fhps_pkg::TimerReset;
            r_codes.status <= fhps_pkg::StatusReset;
        end else begin
            r_codes <= n_codes;
        end
    end

endmodule

// ===== rtl/fhps_in_reg.sv =====
// ----------------------------------------------------------------------------
// fhps_in_reg
// Input register: holds one byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module fhps_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [fhps_pkg::ByteW-1:0]  i_byte,
    input  logic                        i_last,
    output logic                        o_ready,
    input  logic                        i_take,
    output fhps_pkg::t_in_item          o_item
);

    logic                       r_valid;
    logic [fhps_pkg::ByteW-1:0] r_byte;
    logic                       r_last;

    assign o_ready = !r_valid || i_take;

    assign o_item.valid      = r_valid;
    assign o_item.byte_value = r_byte;
    assign o_item.is_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

endmodule

// ===== rtl/fhps_core.sv =====
// ----------------------------------------------------------------------------
// fhps_core
// Field capture, running sum, type match and the result register.
// ----------------------------------------------------------------------------
module fhps_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fhps_pkg::t_in_item     i_item,
    output logic                   o_take,
    input  fhps_pkg::t_type_codes  i_codes,
    output logic                   o_valid,
    input  logic                   i_ready,
    output fhps_pkg::t_result      o_result
);

    logic [fhps_pkg::ByteW-1:0] r_pos;
    logic [fhps_pkg::ByteW-1:0] r_sum;
    logic [fhps_pkg::AddrW-1:0] r_sender;
    logic [fhps_pkg::AddrW-1:0] r_receiver;
    logic [fhps_pkg::CodeW-1:0] r_type;

    logic [fhps_pkg::ByteW-1:0] n_pos;
    logic [fhps_pkg::ByteW-1:0] n_sum;
    logic [fhps_pkg::AddrW-1:0] n_sender;
    logic [fhps_pkg::AddrW-1:0] n_receiver;
    logic [fhps_pkg::CodeW-1:0] n_type;

    logic                  r_out_valid;
    fhps_pkg::t_result     r_out;
    fhps_pkg::t_result     n_out;
    logic [fhps_pkg::ClassW-1:0] w_class;
    logic                  w_short;
    logic                  w_out_free;
    logic                  w_emit;
    logic [fhps_pkg::ByteW-1:0] b;

    assign b          = i_item.byte_value;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_take     = i_item.valid && (!i_item.is_last || w_out_free);
    assign w_emit     = o_take && i_item.is_last;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    // updated state for this byte
    always_comb begin
        n_sender   = r_sender;
        n_receiver = r_receiver;
        n_type     = r_type;
        if (r_pos >= 8'd1 && r_pos <= 8'd3) begin
            n_sender = {r_sender[fhps_pkg::AddrW-fhps_pkg::ByteW-1:0], b};
        end else if (r_pos >= 8'd4 && r_pos <= 8'd6) begin
            n_receiver = {r_receiver[fhps_pkg::AddrW-fhps_pkg::ByteW-1:0], b};
        end else if (r_pos == 8'd7 || r_pos == 8'd8) begin
            n_type = {r_type[fhps_pkg::CodeW-fhps_pkg::ByteW-1:0], b};
        end
        n_sum = r_sum + b;
        n_pos = (r_pos == fhps_pkg::MaxLength) ? r_pos : r_pos + 8'd1;
    end

    // level wins over timer, timer over status
    always_comb begin
        priority if (n_type == i_codes.level) begin
            w_class = fhps_pkg::ClassLevel;
        end else if (n_type == i_codes.timer) begin
            w_class = fhps_pkg::ClassTimer;
        end else if (n_type == i_codes.status) begin
            w_class = fhps_pkg::ClassStatus;
        end else begin
            w_class = fhps_pkg::ClassUnknown;
        end
    end

    assign w_short = n_pos < fhps_pkg::MinLength;

    always_comb begin
        n_out.src_addr       = w_short ? '0 : n_sender;
        n_out.dst_addr       = w_short ? '0 : n_receiver;
        n_out.type_code      = w_short ? '0 : n_type;
        n_out.type_class     = w_short ? fhps_pkg::ClassUnknown : w_class;
        n_out.checksum_ok    = (n_sum == '0);
        n_out.too_short      = w_short;
        n_out.message_length = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_sender   <= '0;
            r_receiver <= '0;
            r_type     <= '0;
        end else if (w_emit) begin
            // start clean for the next message
            r_pos      <= '0;
            r_sum      <= '0;
            r_sender   <= '0;
            r_receiver <= '0;
            r_type     <= '0;
        end else if (o_take) begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_sender   <= n_sender;
            r_receiver <= n_receiver;
            r_type     <= n_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_pos == '0))
        else $error("message state not cleared after final byte");

    a_idle_state_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == '0) |-> (r_sum == '0 && r_sender == '0 && r_receiver == '0
                           && r_type == '0))
        else $error("state not zero at start of message");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_emit))
        else $error("result appeared without a final byte");

    a_short_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.too_short) |->
            (r_out.type_class == fhps_pkg::ClassUnknown && r_out.type_code == '0))
        else $error("short message carries a type");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_emit)
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/frame_header_parse_and_sum_check_top.sv =====
// ----------------------------------------------------------------------------
// frame_header_parse_and_sum_check_top
// Byte stream message parser: addresses, type class and sum-to-zero check.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s       | in        | tdata = byte_value, tlast = is_last
//  m       | out       | one result per message, on its final byte
//  cfg     | in        | index 0 level, 1 timer, 2 status type code
//
//  one byte a cycle while no stalled result holds a final byte back; the final
//  byte sits in the input register and the result register takes it once free,
//  so a result shows after its final byte passes the input and result registers
//  the limit is the combinational capture, sum and three-way compare
//  a stalled result holds only the final byte of the next message back
//  synchronous reset loads the default type codes and clears the state
// ----------------------------------------------------------------------------
module frame_header_parse_and_sum_check_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] byte_value
    input  logic                        i_s_tlast,   // is_last
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [23:0] sender address, [47:24] receiver address,
    // [63:48] type_code, [71:64] message_length
    output logic [71:0]                 o_m_tdata,
    // [1:0] type_class, [2] checksum_ok, [3] too_short
    output logic [3:0]                  o_m_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fhps_pkg::IdxW-1:0]   i_cfg_index,
    input  logic [fhps_pkg::CodeW-1:0]  i_cfg_data
);

    fhps_pkg::t_type_codes w_codes;
    fhps_pkg::t_in_item    w_item;
    fhps_pkg::t_result     w_result;
    logic                  w_take;

    fhps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_codes     (w_codes)
    );

    fhps_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_ready (o_s_tready),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    fhps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .o_take   (w_take),
        .i_codes  (w_codes),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = {w_result.message_length, w_result.type_code,
                        w_result.dst_addr, w_result.src_addr};
    assign o_m_tuser = {w_result.too_short, w_result.checksum_ok, w_result.type_class};

endmodule
